// ----- src/dcl_pkg.sv -----
// ----------------------------------------------------------------------------
// DHCP client lease package
// Types, codes and helpers shared by the lease state machine modules.
// ----------------------------------------------------------------------------
package dcl_pkg;

    localparam int unsigned AddrW   = 32;
    localparam int unsigned QDepth  = 2;
    localparam int unsigned QIdxW   = $clog2(QDepth);
    localparam int unsigned QCntW   = $clog2(QDepth + 1);
    localparam int unsigned NumCfg  = 5;

    localparam logic [AddrW-1:0] LfsrTaps = 32'h8020_0003;
    localparam logic [AddrW-1:0] LfsrSeed = 32'h0000_0001;

    localparam logic [1:0] ActMessage = 2'd0;
    localparam logic [1:0] ActTick    = 2'd1;
    localparam logic [1:0] ActStart   = 2'd2;

    localparam logic [7:0] MsgOffer = 8'd2;
    localparam logic [7:0] MsgAck   = 8'd5;
    localparam logic [7:0] MsgNak   = 8'd6;

    localparam int unsigned FlagMask   = 0;
    localparam int unsigned FlagRouter = 1;
    localparam int unsigned FlagDns1   = 2;
    localparam int unsigned FlagDns2   = 3;

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_SELECTING  = 3'd1,
        ST_REQUESTING = 3'd2,
        ST_BOUND      = 3'd3,
        ST_RENEWING   = 3'd4
    } t_state;

    typedef enum logic [1:0] {
        SEND_NONE = 2'd0,
        SEND_DHCP = 2'd1,
        SEND_ARP  = 2'd2
    } t_send;

    typedef enum logic [2:0] {
        WK_NONE      = 3'd0,
        WK_OFFER     = 3'd1,
        WK_ACK       = 3'd2,
        WK_NAK       = 3'd3,
        WK_MSG_OTHER = 3'd4,
        WK_TICK      = 3'd5,
        WK_START     = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [AddrW-1:0] xid;
        logic             lease_ok;
        logic             router_ok;
        logic [3:0]       flags;
        logic [AddrW-1:0] address;
        logic [AddrW-1:0] server;
        logic [AddrW-1:0] mask;
        logic [AddrW-1:0] router;
        logic [AddrW-1:0] dns1;
        logic [AddrW-1:0] dns2;
        logic [AddrW-1:0] t1;
        logic [AddrW-1:0] t2;
    } t_work;

    function automatic logic [AddrW-1:0] lfsr_step(input logic [AddrW-1:0] cur);
        logic [AddrW-1:0] nxt;
        nxt = cur >> 1;
        if (cur[0]) begin
            nxt = nxt ^ LfsrTaps;
        end
        return nxt;
    endfunction

endpackage

// ----- src/dcl_if.sv -----
// ----------------------------------------------------------------------------
// DHCP client lease channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dcl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] message_xid;
    logic [7:0]  message_type;
    logic [31:0] offered_address;
    logic [31:0] server_identity;
    logic [31:0] lease_seconds;
    logic [3:0]  option_flags;
    logic [31:0] mask_value;
    logic [31:0] router_value;
    logic [31:0] dns_first;
    logic [31:0] dns_second;

    modport source (
        output valid, action, message_xid, message_type, offered_address,
               server_identity, lease_seconds, option_flags, mask_value,
               router_value, dns_first, dns_second,
        input  ready
    );
    modport sink (
        input  valid, action, message_xid, message_type, offered_address,
               server_identity, lease_seconds, option_flags, mask_value,
               router_value, dns_first, dns_second,
        output ready
    );
endinterface

interface dcl_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  client_state;
    logic [1:0]  send_request;
    logic        restarted;
    logic [31:0] current_xid;
    logic [31:0] client_address;
    logic [31:0] client_mask;
    logic [31:0] gateway_address;
    logic [31:0] dns_primary;
    logic [31:0] dns_secondary;
    logic [31:0] lease_server;

    modport source (
        output valid, client_state, send_request, restarted, current_xid,
               client_address, client_mask, gateway_address, dns_primary,
               dns_secondary, lease_server,
        input  ready
    );
    modport sink (
        input  valid, client_state, send_request, restarted, current_xid,
               client_address, client_mask, gateway_address, dns_primary,
               dns_secondary, lease_server,
        output ready
    );
endinterface

// ----- src/dcl_front.sv -----
// ----------------------------------------------------------------------------
// DHCP client lease front end
// Classify each request and precompute lease checks and timer loads.
// ----------------------------------------------------------------------------
module dcl_front
    import dcl_pkg::*;
(
    dcl_req_if.sink          i_req,
    input  logic             i_q_ready,
    output logic             o_q_push,
    output t_work            o_work
);

    logic [AddrW+2:0] w_seven;
    logic [AddrW-1:0] w_half;
    logic [AddrW-1:0] w_t2;

    assign i_req.ready = i_q_ready;
    assign o_q_push    = i_req.valid & i_q_ready;

    // 7*lease as 8*lease - lease, exact in 35 bits
    assign w_seven = {i_req.lease_seconds, 3'b000} - {3'b000, i_req.lease_seconds};
    assign w_half  = i_req.lease_seconds >> 1;
    assign w_t2    = w_seven[AddrW+2:3];

    always_comb begin
        o_work.kind = WK_NONE;
        case (i_req.action)
            ActMessage: begin
                case (i_req.message_type)
                    MsgOffer: o_work.kind = WK_OFFER;
                    MsgAck:   o_work.kind = WK_ACK;
                    MsgNak:   o_work.kind = WK_NAK;
                    default:  o_work.kind = WK_MSG_OTHER;
                endcase
            end
            ActTick:  o_work.kind = WK_TICK;
            ActStart: o_work.kind = WK_START;
            default:  o_work.kind = WK_NONE;
        endcase
        o_work.xid       = i_req.message_xid;
        o_work.lease_ok  = (i_req.offered_address != '0) && (i_req.server_identity != '0)
                           && (i_req.lease_seconds != '0);
        o_work.router_ok = i_req.option_flags[FlagRouter] && (i_req.router_value != '0);
        o_work.flags     = i_req.option_flags;
        o_work.address   = i_req.offered_address;
        o_work.server    = i_req.server_identity;
        o_work.mask      = i_req.mask_value;
        o_work.router    = i_req.router_value;
        o_work.dns1      = i_req.dns_first;
        o_work.dns2      = i_req.dns_second;
        o_work.t1        = (w_half == '0) ? AddrW'(1) : w_half;
        o_work.t2        = (w_t2 == '0) ? AddrW'(1) : w_t2;
    end

endmodule

// ----- src/dcl_queue.sv -----
// ----------------------------------------------------------------------------
// DHCP client lease work queue
// Short FIFO of classified requests between front end and back end.
// ----------------------------------------------------------------------------
module dcl_queue
    import dcl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_pop,
    output t_work o_work
);

    t_work            r_mem [QDepth];
    logic [QIdxW-1:0] r_wr_ptr;
    logic [QIdxW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;
    logic [QIdxW-1:0] n_wr_ptr;
    logic [QIdxW-1:0] n_rd_ptr;
    logic [QCntW-1:0] n_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != QCntW'(QDepth));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rd_ptr];
    assign w_push  = i_push & o_ready;
    assign w_pop   = i_pop & o_valid;

    always_comb begin
        n_wr_ptr = w_push ? ((r_wr_ptr == QIdxW'(QDepth - 1)) ? '0 : r_wr_ptr + 1'b1)
                          : r_wr_ptr;
        n_rd_ptr = w_pop  ? ((r_rd_ptr == QIdxW'(QDepth - 1)) ? '0 : r_rd_ptr + 1'b1)
                          : r_rd_ptr;
        n_count  = r_count + QCntW'(w_push) - QCntW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

endmodule

// ----- src/dcl_back.sv -----
// ----------------------------------------------------------------------------
// DHCP client lease back end
// Session state, lease timers and registered result per request.
// ----------------------------------------------------------------------------
module dcl_back
    import dcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_work      i_work,
    output logic       o_pop,
    dcl_rsp_if.source  o_rsp
);

    t_state           r_state;
    t_state           n_state;
    logic [AddrW-1:0] r_xid;
    logic [AddrW-1:0] n_xid;
    logic [AddrW-1:0] r_lfsr;
    logic [AddrW-1:0] n_lfsr;
    logic [AddrW-1:0] r_server;
    logic [AddrW-1:0] n_server;
    logic [AddrW-1:0] r_cfg [NumCfg];
    logic [AddrW-1:0] n_cfg [NumCfg];
    logic [AddrW-1:0] r_renew_cnt;
    logic [AddrW-1:0] n_renew_cnt;
    logic [AddrW-1:0] r_rebind_cnt;
    logic [AddrW-1:0] n_rebind_cnt;
    logic             r_renew_armed;
    logic             n_renew_armed;
    logic             r_rebind_armed;
    logic             n_rebind_armed;
    logic             r_out_valid;
    t_send            r_out_send;
    t_send            n_send;
    logic             r_out_restart;

    logic             w_pop;
    logic             w_xid_hit;
    logic [AddrW-1:0] w_rn_dec;
    logic [AddrW-1:0] w_rb_dec;
    logic             w_rn_fire;
    logic             w_rb_fire;
    logic             w_tick;
    logic             w_offer_go;
    logic             w_ack_go;
    logic             w_nak_go;
    logic             w_first;
    logic             w_restart;
    logic             w_offer_ok;
    logic             w_ack_ok;
    logic             w_renew_move;

    assign o_pop     = i_valid & (~r_out_valid | o_rsp.ready);
    assign w_pop     = o_pop;
    assign w_xid_hit = (i_work.xid == r_xid);
    assign w_tick    = w_pop && (i_work.kind == WK_TICK);

    assign w_rn_dec  = r_renew_cnt - AddrW'(r_renew_cnt != '0);
    assign w_rb_dec  = r_rebind_cnt - AddrW'(r_rebind_cnt != '0);
    assign w_rn_fire = r_renew_armed && (w_rn_dec == '0);
    assign w_rb_fire = r_rebind_armed && (w_rb_dec == '0);

    assign w_first    = (r_state == ST_REQUESTING);
    assign w_offer_go = w_pop && (i_work.kind == WK_OFFER) && w_xid_hit
                        && (r_state == ST_SELECTING);
    assign w_ack_go   = w_pop && (i_work.kind == WK_ACK) && w_xid_hit
                        && (w_first || (r_state == ST_RENEWING));
    assign w_nak_go   = w_pop && (i_work.kind == WK_NAK) && w_xid_hit
                        && (w_first || (r_state == ST_RENEWING));

    assign w_offer_ok = w_offer_go && i_work.lease_ok;
    assign w_ack_ok   = w_ack_go && i_work.lease_ok && (!w_first || i_work.router_ok);
    assign w_restart  = (w_pop && (i_work.kind == WK_START)) || (w_tick && w_rb_fire)
                        || (w_offer_go && !i_work.lease_ok) || (w_ack_go && !w_ack_ok)
                        || w_nak_go;
    assign w_renew_move = w_tick && w_rn_fire && (r_state == ST_BOUND);

    always_comb begin
        n_state = r_state;
        if (w_restart) begin
            n_state = ST_SELECTING;
        end else if (w_offer_ok) begin
            n_state = ST_REQUESTING;
        end else if (w_ack_ok) begin
            n_state = ST_BOUND;
        end else if (w_renew_move) begin
            n_state = ST_RENEWING;
        end
    end

    always_comb begin
        n_xid          = r_xid;
        n_lfsr         = r_lfsr;
        n_server       = r_server;
        n_cfg          = r_cfg;
        n_renew_cnt    = r_renew_cnt;
        n_rebind_cnt   = r_rebind_cnt;
        n_renew_armed  = r_renew_armed;
        n_rebind_armed = r_rebind_armed;
        n_send         = SEND_NONE;
        if (w_restart) begin
            n_lfsr         = lfsr_step(r_lfsr);
            n_xid          = n_lfsr;
            n_server       = '0;
            for (int i = 0; i < NumCfg; i++) begin
                n_cfg[i] = '0;
            end
            n_renew_cnt    = '0;
            n_rebind_cnt   = '0;
            n_renew_armed  = 1'b0;
            n_rebind_armed = 1'b0;
            n_send         = SEND_DHCP;
        end else if (w_offer_ok) begin
            n_server       = i_work.server;
            n_rebind_cnt   = i_work.t2;
            n_rebind_armed = 1'b1;
            n_send         = SEND_DHCP;
        end else if (w_ack_ok) begin
            n_server       = i_work.server;
            if (w_first) begin
                n_cfg[0] = i_work.address;
                n_cfg[2] = i_work.router;
                if (i_work.flags[FlagMask]) begin
                    n_cfg[1] = i_work.mask;
                end
                if (i_work.flags[FlagDns1]) begin
                    n_cfg[3] = i_work.dns1;
                end
                if (i_work.flags[FlagDns2]) begin
                    n_cfg[4] = i_work.dns2;
                end
            end
            n_renew_cnt    = i_work.t1;
            n_renew_armed  = 1'b1;
            n_rebind_cnt   = i_work.t2;
            n_rebind_armed = 1'b1;
            n_send         = SEND_ARP;
        end else if (w_tick) begin
            if (r_rebind_armed) begin
                n_rebind_cnt = w_rb_dec;
            end
            if (r_renew_armed) begin
                n_renew_cnt   = w_rn_dec;
                n_renew_armed = !w_rn_fire;
            end
            if (w_renew_move) begin
                n_send = SEND_DHCP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_xid          <= '0;
            r_lfsr         <= LfsrSeed;
            r_server       <= '0;
            for (int i = 0; i < NumCfg; i++) begin
                r_cfg[i] <= '0;
            end
            r_renew_cnt    <= '0;
            r_rebind_cnt   <= '0;
            r_renew_armed  <= 1'b0;
            r_rebind_armed <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_pop) begin
                r_state        <= n_state;
                r_xid          <= n_xid;
                r_lfsr         <= n_lfsr;
                r_server       <= n_server;
                r_cfg          <= n_cfg;
                r_renew_cnt    <= n_renew_cnt;
                r_rebind_cnt   <= n_rebind_cnt;
                r_renew_armed  <= n_renew_armed;
                r_rebind_armed <= n_rebind_armed;
                r_out_valid    <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_send    <= n_send;
            r_out_restart <= w_restart;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.client_state    = r_state;
    assign o_rsp.send_request    = r_out_send;
    assign o_rsp.restarted       = r_out_restart;
    assign o_rsp.current_xid     = r_xid;
    assign o_rsp.client_address  = r_cfg[0];
    assign o_rsp.client_mask     = r_cfg[1];
    assign o_rsp.gateway_address = r_cfg[2];
    assign o_rsp.dns_primary     = r_cfg[3];
    assign o_rsp.dns_secondary   = r_cfg[4];
    assign o_rsp.lease_server    = r_server;

endmodule

// ----- src/dhcp_client_lease_fsm_core.sv -----
// ----------------------------------------------------------------------------
// DHCP client lease state machine
// One client session: selecting, requesting, bound, renewing, lease timers.
// ----------------------------------------------------------------------------
//  port     dir  handshake     request
//  i_req    in   valid/ready   message, one-second tick or start
//  o_rsp    out  valid/ready   state, send code, restart flag, xid, lease info
//
//  One request per cycle sustained while o_rsp is ready; each result is
//  offered after its request passes the queue entry and the back end's
//  state update into the result register. A two-entry queue parts
//  classification from execution; the result register holds while o_rsp
//  stalls and the queue keeps taking requests until it is full. Reset is
//  synchronous and leaves the session idle.
// ----------------------------------------------------------------------------
module dhcp_client_lease_fsm_core
    import dcl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcl_req_if.sink   i_req,
    dcl_rsp_if.source o_rsp
);

    logic  w_q_ready;
    logic  w_q_push;
    t_work w_front_work;
    logic  w_q_valid;
    logic  w_q_pop;
    t_work w_back_work;

    dcl_front u_front (
        .i_req     (i_req),
        .i_q_ready (w_q_ready),
        .o_q_push  (w_q_push),
        .o_work    (w_front_work)
    );

    dcl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_work  (w_front_work),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_work  (w_back_work)
    );

    dcl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_work  (w_back_work),
        .o_pop   (w_q_pop),
        .o_rsp   (o_rsp)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DHCP client lease state machine testbench
// Drives messages, one-second ticks and starts into the core and checks
// every result against an in-bench model of the session and lease timers.
// Directed cases come first, then a receiver hold-off that fills the core,
// then random sessions, both channels gapped but in each fourth 90 items.
// ----------------------------------------------------------------------------
module tb;
    import dcl_pkg::*;

    localparam logic [1:0] ActUnused = 2'd3;
    localparam logic [7:0] MsgBogus  = 8'd255;
    localparam int         LongHold  = 200;
    localparam int         NumItems  = 750;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] xid;
        logic [7:0]  mtype;
        logic [31:0] address;
        logic [31:0] server;
        logic [31:0] lease;
        logic [3:0]  flags;
        logic [31:0] mask;
        logic [31:0] router;
        logic [31:0] dns1;
        logic [31:0] dns2;
    } t_dhcp_event;

    typedef struct packed {
        logic [2:0]  state;
        logic [1:0]  send;
        logic        restarted;
        logic [31:0] xid;
        logic [31:0] address;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [31:0] dns1;
        logic [31:0] dns2;
        logic [31:0] server;
    } t_lease_status;

    logic i_clk;
    logic i_rst_n;

    dcl_req_if req_ch ();
    dcl_rsp_if rsp_ch ();

    dhcp_client_lease_fsm_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // session model
    t_state      m_state;
    logic [31:0] m_xid;
    logic [31:0] m_lfsr;
    logic [31:0] m_lease_addr;
    logic [31:0] m_lease_srv;
    logic [31:0] m_lease_len;
    logic [31:0] m_cfg [NumCfg];
    logic [31:0] m_renew_left;
    logic [31:0] m_rebind_left;
    bit          m_renew_on;
    bit          m_rebind_on;
    t_send       p_send;
    bit          p_restart;

    t_lease_status expected_status_q [$];
    t_lease_status want_st;
    int          err_count;
    bit          tx_gaps_on;
    bit          rx_gaps_on;
    bit          long_hold_req;
    int          hold_left;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] renew_time(input logic [31:0] lease);
        logic [31:0] t;
        t = lease >> 1;
        return (t == 32'd0) ? 32'd1 : t;
    endfunction

    function automatic logic [31:0] rebind_time(input logic [31:0] lease);
        logic [34:0] prod;
        logic [31:0] t;
        prod = {3'b000, lease} * 35'd7;
        t    = prod[34:3];
        return (t == 32'd0) ? 32'd1 : t;
    endfunction

    function automatic void reset_session_model();
        m_state       = ST_IDLE;
        m_xid         = '0;
        m_lfsr        = LfsrSeed;
        m_lease_addr  = '0;
        m_lease_srv   = '0;
        m_lease_len   = '0;
        m_renew_left  = '0;
        m_rebind_left = '0;
        m_renew_on    = 1'b0;
        m_rebind_on   = 1'b0;
        for (int i = 0; i < NumCfg; i++) begin
            m_cfg[i] = '0;
        end
    endfunction

    function automatic void session_restart();
        logic [31:0] nxt;
        nxt = m_lfsr >> 1;
        if (m_lfsr[0]) begin
            nxt = nxt ^ LfsrTaps;
        end
        reset_session_model();
        m_lfsr    = nxt;
        m_xid     = nxt;
        m_state   = ST_SELECTING;
        p_send    = SEND_DHCP;
        p_restart = 1'b1;
    endfunction

    function automatic bit latch_lease(input t_dhcp_event ev);
        m_lease_addr = ev.address;
        m_lease_srv  = ev.server;
        m_lease_len  = ev.lease;
        return (ev.address != '0) && (ev.server != '0) && (ev.lease != '0);
    endfunction

    function automatic t_lease_status predict_lease_status(input t_dhcp_event ev);
        t_lease_status st;
        bit            first;
        bit            fire_rebind;
        p_send      = SEND_NONE;
        p_restart   = 1'b0;
        fire_rebind = 1'b0;
        case (ev.action)
            ActMessage: begin
                if (ev.xid == m_xid) begin
                    case (m_state)
                        ST_SELECTING: begin
                            if (ev.mtype == MsgOffer) begin
                                m_state = ST_REQUESTING;
                                if (!latch_lease(ev)) begin
                                    session_restart();
                                end else begin
                                    m_rebind_left = rebind_time(m_lease_len);
                                    m_rebind_on   = 1'b1;
                                    p_send        = SEND_DHCP;
                                end
                            end
                        end
                        ST_REQUESTING, ST_RENEWING: begin
                            if (ev.mtype == MsgAck) begin
                                first   = (m_state == ST_REQUESTING);
                                m_state = ST_BOUND;
                                if (!latch_lease(ev)) begin
                                    session_restart();
                                end else if (first &&
                                    !(ev.flags[FlagRouter] && ev.router != '0)) begin
                                    session_restart();
                                end else begin
                                    if (first) begin
                                        m_cfg[0] = m_lease_addr;
                                        m_cfg[2] = ev.router;
                                        if (ev.flags[FlagMask]) m_cfg[1] = ev.mask;
                                        if (ev.flags[FlagDns1]) m_cfg[3] = ev.dns1;
                                        if (ev.flags[FlagDns2]) m_cfg[4] = ev.dns2;
                                    end
                                    m_renew_left  = renew_time(m_lease_len);
                                    m_renew_on    = 1'b1;
                                    m_rebind_left = rebind_time(m_lease_len);
                                    m_rebind_on   = 1'b1;
                                    p_send        = SEND_ARP;
                                end
                            end else if (ev.mtype == MsgNak) begin
                                session_restart();
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ActTick: begin
                if (m_rebind_on) begin
                    if (m_rebind_left != '0) m_rebind_left = m_rebind_left - 1;
                    if (m_rebind_left == '0) begin
                        m_rebind_on = 1'b0;
                        fire_rebind = 1'b1;
                    end
                end
                if (m_renew_on) begin
                    if (m_renew_left != '0) m_renew_left = m_renew_left - 1;
                    if (m_renew_left == '0) begin
                        m_renew_on = 1'b0;
                        if (m_state == ST_BOUND) begin
                            m_state = ST_RENEWING;
                            p_send  = SEND_DHCP;
                        end
                    end
                end
                if (fire_rebind) begin
                    session_restart();
                end
            end
            ActStart: begin
                session_restart();
            end
            default: ;
        endcase
        st.state     = m_state;
        st.send      = p_send;
        st.restarted = p_restart;
        st.xid       = m_xid;
        st.address   = m_cfg[0];
        st.mask      = m_cfg[1];
        st.gateway   = m_cfg[2];
        st.dns1      = m_cfg[3];
        st.dns2      = m_cfg[4];
        st.server    = m_lease_srv;
        return st;
    endfunction

    function automatic t_dhcp_event ev_msg(input logic [31:0] xid, input logic [7:0] mtype,
                                           input logic [31:0] address, input logic [31:0] server,
                                           input logic [31:0] lease, input logic [3:0] flags,
                                           input logic [31:0] router);
        t_dhcp_event ev;
        ev.action  = ActMessage;
        ev.xid     = xid;
        ev.mtype   = mtype;
        ev.address = address;
        ev.server  = server;
        ev.lease   = lease;
        ev.flags   = flags;
        ev.mask    = $urandom;
        ev.router  = router;
        ev.dns1    = $urandom;
        ev.dns2    = $urandom;
        return ev;
    endfunction

    function automatic t_dhcp_event ev_ctl(input logic [1:0] action);
        t_dhcp_event ev;
        ev        = ev_msg($urandom, 8'($urandom), $urandom, $urandom, $urandom,
                           4'($urandom), $urandom);
        ev.action = action;
        return ev;
    endfunction

    function automatic logic [31:0] field_or_zero(input int zero_pct);
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 99) < zero_pct) return '0;
        return (v == '0) ? 32'd1 : v;
    endfunction

    function automatic logic [31:0] pick_lease();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r <= 2) return $urandom;
        return $urandom_range(1, 24);
    endfunction

    function automatic void make_session_event(output t_dhcp_event ev, output bit noise);
        int          r;
        logic [3:0]  flags;
        noise = 1'b0;
        r     = $urandom_range(0, 99);
        flags = 4'($urandom);
        if ($urandom_range(0, 99) < 85) flags[FlagRouter] = 1'b1;
        if ($urandom_range(0, 99) < 6) begin
            ev        = ev_ctl(2'($urandom_range(0, 3)));
            ev.flags  = 4'($urandom);
            noise     = 1'b1;
            return;
        end
        case (m_state)
            ST_IDLE: ev = ev_ctl(ActStart);
            ST_SELECTING: begin
                if (r < 75) begin
                    ev = ev_msg(m_xid, MsgOffer, field_or_zero(5), field_or_zero(5),
                                pick_lease(), flags, field_or_zero(5));
                end else if (r < 85) begin
                    ev = ev_ctl(ActTick);
                end else if (r < 92) begin
                    ev       = ev_ctl(ActMessage);
                    ev.xid   = m_xid;
                end else begin
                    ev = ev_ctl(ActStart);
                end
            end
            ST_REQUESTING, ST_RENEWING: begin
                if (r < 60) begin
                    ev = ev_msg(m_xid, MsgAck, field_or_zero(5), field_or_zero(5),
                                pick_lease(), flags, field_or_zero(8));
                end else if (r < 70) begin
                    ev = ev_msg(m_xid, MsgNak, $urandom, $urandom, $urandom, flags, $urandom);
                end else if (r < 90) begin
                    ev = ev_ctl(ActTick);
                end else if (r < 95) begin
                    ev = ev_msg(~m_xid, MsgAck, field_or_zero(0), field_or_zero(0),
                                pick_lease(), flags, field_or_zero(0));
                end else begin
                    ev = ev_ctl(ActStart);
                end
            end
            default: begin
                if (r < 85) begin
                    ev = ev_ctl(ActTick);
                end else if (r < 94) begin
                    ev = ev_msg(m_xid, (r < 90) ? MsgAck : MsgOffer, field_or_zero(0),
                                field_or_zero(0), pick_lease(), flags, field_or_zero(0));
                end else begin
                    ev = ev_ctl(ActStart);
                end
            end
        endcase
    endfunction

    task automatic drive_fields(input t_dhcp_event ev);
        req_ch.action          <= ev.action;
        req_ch.message_xid     <= ev.xid;
        req_ch.message_type    <= ev.mtype;
        req_ch.offered_address <= ev.address;
        req_ch.server_identity <= ev.server;
        req_ch.lease_seconds   <= ev.lease;
        req_ch.option_flags    <= ev.flags;
        req_ch.mask_value      <= ev.mask;
        req_ch.router_value    <= ev.router;
        req_ch.dns_first       <= ev.dns1;
        req_ch.dns_second      <= ev.dns2;
    endtask

    task automatic drive_request(input t_dhcp_event ev);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        drive_fields(ev);
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        expected_status_q.push_back(predict_lease_status(ev));
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 50) begin
            $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_status_q.size() == 0) begin
                report_mismatch("result with no request pending", rsp_ch.current_xid, 'x);
            end else begin
                want_st = expected_status_q.pop_front();
                check_field("client_state", 32'(rsp_ch.client_state), 32'(want_st.state));
                check_field("send_request", 32'(rsp_ch.send_request), 32'(want_st.send));
                check_field("restarted", 32'(rsp_ch.restarted), 32'(want_st.restarted));
                check_field("current_xid", rsp_ch.current_xid, want_st.xid);
                check_field("client_address", rsp_ch.client_address, want_st.address);
                check_field("client_mask", rsp_ch.client_mask, want_st.mask);
                check_field("gateway_address", rsp_ch.gateway_address, want_st.gateway);
                check_field("dns_primary", rsp_ch.dns_primary, want_st.dns1);
                check_field("dns_secondary", rsp_ch.dns_secondary, want_st.dns2);
                check_field("lease_server", rsp_ch.lease_server, want_st.server);
            end
        end
    end

    // result ready: random stalls plus one long hold-off on request
    initial begin
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LongHold;
            end
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left = gap_len() - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        drive_request(ev_ctl(ActTick));
        drive_request(ev_msg(m_xid, MsgOffer, 32'h0a00_0001, 32'h0a00_00fe, 32'd100, 4'hf,
                             32'h0a00_00fe));
        drive_request(ev_ctl(ActUnused));
        drive_request(ev_ctl(ActStart));
        drive_request(ev_msg(m_xid + 1, MsgOffer, 32'h0a00_0001, 32'h0a00_00fe, 32'd10,
                             4'hf, 32'h1));
        drive_request(ev_msg(m_xid, MsgAck, 32'h0a00_0001, 32'h0a00_00fe, 32'd10, 4'hf,
                             32'h1));
        drive_request(ev_msg(m_xid, MsgOffer, '0, 32'h0a00_00fe, 32'd10, 4'hf, 32'h1));
        drive_request(ev_msg(m_xid, MsgOffer, 32'h0a00_0002, 32'h0a00_00fe, 32'd1, 4'h0,
                             32'h0));
        drive_request(ev_msg(m_xid, MsgBogus, 32'h0a00_0002, 32'h0a00_00fe, 32'd1, 4'hf,
                             32'h1));
        drive_request(ev_msg(m_xid, MsgAck, 32'h0a00_0002, 32'h0a00_00fe, 32'd1, 4'hd,
                             32'h0a00_0001));
        drive_request(ev_msg(m_xid, MsgOffer, '1, '1, '1, 4'hf, '1));
        drive_request(ev_msg(m_xid, MsgAck, '1, '1, '1, 4'hf, '0));
        drive_request(ev_msg(m_xid, MsgOffer, 32'hc0a8_0164, 32'hc0a8_0101, 32'd2, 4'h0,
                             32'h0));
        drive_request(ev_msg(m_xid, MsgAck, 32'hc0a8_0164, 32'hc0a8_0101, 32'd2, 4'hf,
                             32'hc0a8_0101));
        // both timers expire on this tick
        drive_request(ev_ctl(ActTick));
        drive_request(ev_msg(m_xid, MsgOffer, 32'hc0a8_0165, 32'hc0a8_0101, 32'd4, 4'h0,
                             32'h0));
        drive_request(ev_msg(m_xid, MsgNak, '0, '0, '0, 4'h0, '0));
        drive_request(ev_msg(m_xid, MsgOffer, 32'hc0a8_0166, 32'hc0a8_0101, 32'd4, 4'h0,
                             32'h0));
        drive_request(ev_msg(m_xid, MsgAck, 32'hc0a8_0166, 32'hc0a8_0101, 32'd4, 4'h3,
                             32'hc0a8_0101));
        drive_request(ev_ctl(ActTick));
        drive_request(ev_ctl(ActTick));
        drive_request(ev_msg(m_xid, MsgAck, 32'hc0a8_0166, 32'hc0a8_0102, '1, 4'h0, '0));
        drive_request(ev_ctl(ActStart));
        drive_request(ev_msg(m_xid, MsgOffer, 32'hc0a8_0167, 32'hc0a8_0101, 32'd8, 4'h0,
                             32'h0));
        drive_request(ev_msg(m_xid, MsgAck, 32'hc0a8_0167, '0, 32'd8, 4'hf, 32'h1));
        wait_drain();
    endtask

    task automatic test_backpressure();
        t_dhcp_event ev;
        bit          noise;
        tx_gaps_on    = 1'b0;
        long_hold_req = 1'b1;
        repeat (16) begin
            make_session_event(ev, noise);
            drive_request(ev);
        end
        wait_drain();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_sessions();
        t_dhcp_event ev;
        bit          noise;
        int          count;
        count = 0;
        while (count < NumItems) begin
            tx_gaps_on = ((count / 90) % 4) != 3;
            rx_gaps_on = tx_gaps_on;
            make_session_event(ev, noise);
            drive_request(ev);
            if (!noise) count++;
        end
        wait_drain();
    endtask

    initial begin
        err_count     = 0;
        tx_gaps_on    = 1'b1;
        rx_gaps_on    = 1'b1;
        long_hold_req = 1'b0;
        reset_session_model();
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        drive_fields('0);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_sessions();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && expected_status_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/dcl_pkg.sv
src/dcl_if.sv
src/dcl_front.sv
src/dcl_queue.sv
src/dcl_back.sv
src/dhcp_client_lease_fsm_core.sv
verif/tb.sv
